>>> hw/rtl/mrc_pkg.sv
package mrc_pkg;

   localparam int MAX_FRAME = 256;

   // byte counter saturates at MAX_FRAME + 1
   localparam int CNT_W = $clog2(MAX_FRAME + 2);

   localparam logic [CNT_W-1:0] CNT_SAT  = CNT_W'(MAX_FRAME + 1);
   localparam logic [CNT_W-1:0] LEN_MAX  = CNT_W'(MAX_FRAME);
   localparam logic [CNT_W-1:0] LEN_MIN  = CNT_W'(4);
   localparam logic [CNT_W-1:0] POS_FUNC = CNT_W'(1);
   localparam logic [CNT_W-1:0] POS_VHI  = CNT_W'(3);
   localparam logic [CNT_W-1:0] POS_VLO  = CNT_W'(4);
   localparam logic [CNT_W-1:0] POS_CRC  = CNT_W'(2);

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;
   localparam logic [7:0]  FN_READ  = 8'h03;
   localparam logic [7:0]  FN_WRITE = 8'h06;

   typedef enum logic [2:0] {
      ST_READ_OK   = 3'd0,
      ST_WRITE_ACK = 3'd1,
      ST_CRC_ERR   = 3'd2,
      ST_BAD_FUNC  = 3'd3,
      ST_BAD_LEN   = 3'd4
   } status_type;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      status_type  status;
      logic [15:0] read_value;
      logic [7:0]  function_code;
   } rsp_type;

   // one byte of reflected crc-16/modbus, unrolled
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

>>> hw/rtl/mrc_frame_core.sv
module mrc_frame_core (
   input  logic            clock,
   input  logic            reset,
   input  logic            item_go,
   input  mrc_pkg::req_type item,
   output mrc_pkg::rsp_type result
);
   import mrc_pkg::*;

   logic [15:0]      crc_ff, crc_in;
   logic [7:0]       older_ff, older_in;
   logic [7:0]       newer_ff, newer_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [7:0]       func_ff, func_in;
   logic [7:0]       vhi_ff, vhi_in;
   logic [7:0]       vlo_ff, vlo_in;

   logic [15:0]      crc_fed;
   logic [CNT_W-1:0] count_nx;
   logic [7:0]       func_nx, vhi_nx, vlo_nx;
   logic [15:0]      recv_crc;

   always_comb begin
      // the byte two places back can no longer be part of the trailing crc
      crc_fed  = (count_ff >= POS_CRC) ? crc_byte(crc_ff, older_ff) : crc_ff;
      count_nx = (count_ff < CNT_SAT) ? count_ff + CNT_W'(1) : count_ff;
      func_nx  = (count_ff == POS_FUNC) ? item.rx_byte : func_ff;
      vhi_nx   = (count_ff == POS_VHI) ? item.rx_byte : vhi_ff;
      vlo_nx   = (count_ff == POS_VLO) ? item.rx_byte : vlo_ff;
      recv_crc = {item.rx_byte, newer_ff};
   end

   always_comb begin
      result.function_code = func_nx;
      result.read_value    = 16'h0000;
      if (count_nx < LEN_MIN || count_nx > LEN_MAX) begin
         result.status = ST_BAD_LEN;
      end else if (crc_fed != recv_crc) begin
         result.status = ST_CRC_ERR;
      end else if (func_nx == FN_READ) begin
         result.status     = ST_READ_OK;
         result.read_value = {vhi_nx, vlo_nx};
      end else if (func_nx == FN_WRITE) begin
         result.status = ST_WRITE_ACK;
      end else begin
         result.status = ST_BAD_FUNC;
      end
   end

   always_comb begin
      crc_in   = crc_ff;
      older_in = older_ff;
      newer_in = newer_ff;
      count_in = count_ff;
      func_in  = func_ff;
      vhi_in   = vhi_ff;
      vlo_in   = vlo_ff;
      if (item_go) begin
         if (item.last_byte) begin
            // frame done: back to the idle frame state
            crc_in   = CRC_INIT;
            older_in = 8'h00;
            newer_in = 8'h00;
            count_in = '0;
            func_in  = 8'h00;
            vhi_in   = 8'h00;
            vlo_in   = 8'h00;
         end else begin
            crc_in   = crc_fed;
            older_in = newer_ff;
            newer_in = item.rx_byte;
            count_in = count_nx;
            func_in  = func_nx;
            vhi_in   = vhi_nx;
            vlo_in   = vlo_nx;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff   <= CRC_INIT;
         older_ff <= 8'h00;
         newer_ff <= 8'h00;
         count_ff <= '0;
         func_ff  <= 8'h00;
         vhi_ff   <= 8'h00;
         vlo_ff   <= 8'h00;
      end else begin
         crc_ff   <= crc_in;
         older_ff <= older_in;
         newer_ff <= newer_in;
         count_ff <= count_in;
         func_ff  <= func_in;
         vhi_ff   <= vhi_in;
         vlo_ff   <= vlo_in;
      end
   end

   a_count_sat: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_SAT)
      else $error("byte count past saturation");

   a_frame_clear: assert property (@(posedge clock) disable iff (reset)
      (item_go && item.last_byte) |=> (count_ff == '0 && crc_ff == CRC_INIT))
      else $error("frame state not cleared after last byte");

   a_no_crc_early: assert property (@(posedge clock) disable iff (reset)
      (count_ff < POS_CRC) |-> (crc_ff == CRC_INIT))
      else $error("crc advanced before third byte");

endmodule

>>> hw/rtl/modbus_rtu_response_checker_top.sv
// channel  direction  handshake              payload
// req      in         req_valid / req_ready  req_data (mrc_pkg::req_type)
// rsp      out        rsp_valid / rsp_ready  rsp_data (mrc_pkg::rsp_type)
//
// one byte transaction per cycle sustained, unless a stalled rsp holds the input stage; a
// result leaves through the input register, then the result register, after its last byte is taken.
// the crc is one unrolled 8-bit step on the core state registers, feeding state and result registers.
// reset is synchronous, active high, and clears all frame state.
// a stalled rsp only holds the input stage when it carries a last byte.
module modbus_rtu_response_checker_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  mrc_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output mrc_pkg::rsp_type rsp_data
);
   import mrc_pkg::*;

   logic    s1_valid_ff, s1_valid_in;
   req_type s1_data_ff, s1_data_in;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;
   logic    s1_go;
   rsp_type core_result;

   always_comb begin
      s1_go     = s1_valid_ff && (!s1_data_ff.last_byte || !rsp_valid_ff || rsp_ready);
      req_ready = !s1_valid_ff || s1_go;
   end

   mrc_frame_core u_core (
      .clock   (clock),
      .reset   (reset),
      .item_go (s1_go),
      .item    (s1_data_ff),
      .result  (core_result)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_data_in  = s1_data_ff;
      if (req_valid && req_ready) begin
         s1_valid_in = 1'b1;
         s1_data_in  = req_data;
      end else if (s1_go) begin
         s1_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (s1_go && s1_data_ff.last_byte) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = core_result;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_data_ff  <= s1_data_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_last_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      (s1_go && s1_data_ff.last_byte) |=> rsp_valid_ff)
      else $error("last byte did not produce a result");

   a_stall_only_last: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (s1_valid_ff && s1_data_ff.last_byte && rsp_valid_ff && !rsp_ready))
      else $error("input stalled without a blocked result");

   a_value_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.status != ST_READ_OK) |-> (rsp_data_ff.read_value == 16'h0000))
      else $error("read value nonzero on non-read status");

endmodule

>>> tb/modbus_rtu_response_checker_top_tb.sv
`timescale 1ns / 1ps

module modbus_rtu_response_checker_top_tb;
   import mrc_pkg::*;

   localparam int unsigned ITEM_TARGET = 1850;
   localparam int unsigned HOLD_CYCLES = 400;
   localparam int unsigned DRAIN_TAIL  = 8;
   localparam int unsigned STALL_LIMIT = 3000;

   // tracks one frame at a time and queues the reply each last byte should cause
   class rtu_reply_tracker;
      logic [15:0]  crc_acc;
      logic [7:0]   held_old;
      logic [7:0]   held_new;
      logic [7:0]   func;
      logic [7:0]   val_hi;
      logic [7:0]   val_lo;
      int unsigned  nbytes;
      rsp_type      due_replies[$];
      int unsigned  failures;

      function new();
         failures = 0;
         clear_frame();
      endfunction

      function void clear_frame();
         crc_acc  = CRC_INIT;
         held_old = '0;
         held_new = '0;
         func     = '0;
         val_hi   = '0;
         val_lo   = '0;
         nbytes   = 0;
      endfunction

      // reflected crc-16, one data bit at a time
      static function logic [15:0] crc_next(input logic [15:0] acc, input logic [7:0] d);
         logic fb;
         for (int i = 0; i < 8; i++) begin
            fb  = acc[0] ^ d[i];
            acc = acc >> 1;
            if (fb) begin
               acc = acc ^ 16'hA001;
            end
         end
         return acc;
      endfunction

      function void take_byte(input req_type t);
         rsp_type     r;
         logic [15:0] wire_crc;
         // the byte two places back can no longer be part of the trailing crc
         if (nbytes >= 2) begin
            crc_acc = crc_next(crc_acc, held_old);
         end
         held_old = held_new;
         held_new = t.rx_byte;
         case (nbytes)
            1: func   = t.rx_byte;
            3: val_hi = t.rx_byte;
            4: val_lo = t.rx_byte;
            default: ;
         endcase
         if (nbytes < MAX_FRAME + 1) begin
            nbytes++;
         end
         if (!t.last_byte) begin
            return;
         end
         wire_crc        = {held_new, held_old};
         r.read_value    = '0;
         r.function_code = func;
         if (nbytes < 4 || nbytes > MAX_FRAME) begin
            r.status = ST_BAD_LEN;
         end else if (crc_acc != wire_crc) begin
            r.status = ST_CRC_ERR;
         end else if (func == FN_READ) begin
            r.status     = ST_READ_OK;
            r.read_value = {val_hi, val_lo};
         end else if (func == FN_WRITE) begin
            r.status = ST_WRITE_ACK;
         end else begin
            r.status = ST_BAD_FUNC;
         end
         due_replies.push_back(r);
         clear_frame();
      endfunction

      function void match_reply(input rsp_type got);
         rsp_type want;
         if (due_replies.size() == 0) begin
            $error("reply with none outstanding: status %0d value %h function %h",
                   got.status, got.read_value, got.function_code);
            failures++;
            return;
         end
         want = due_replies.pop_front();
         if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            failures++;
         end
         if (got.read_value !== want.read_value) begin
            $error("read_value: expected %h, got %h", want.read_value, got.read_value);
            failures++;
         end
         if (got.function_code !== want.function_code) begin
            $error("function_code: expected %h, got %h", want.function_code,
                   got.function_code);
            failures++;
         end
      endfunction

      function int unsigned outstanding();
         return due_replies.size();
      endfunction
   endclass

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   rtu_reply_tracker replies = new();
   logic [7:0]       fb[$];
   int unsigned      items_sent = 0;
   int unsigned      quiet = 0;
   bit               calm = 1'b0;
   bit               hold_rsp = 1'b0;

   modbus_rtu_response_checker_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (calm || r < 50) begin
         return 0;
      end else if (r < 85) begin
         return $urandom_range(1, 3);
      end else if (r < 97) begin
         return $urandom_range(4, 10);
      end
      return $urandom_range(20, 60);
   endfunction

   function automatic void append_crc(input bit corrupt);
      logic [15:0] c;
      int unsigned k;
      c = CRC_INIT;
      foreach (fb[i]) begin
         c = rtu_reply_tracker::crc_next(c, fb[i]);
      end
      if (corrupt) begin
         k    = $urandom_range(0, 15);
         c[k] = ~c[k];
      end
      fb.push_back(c[7:0]);
      fb.push_back(c[15:8]);
   endfunction

   function automatic void build_frame(input int unsigned len, input logic [7:0] func,
                                       input bit corrupt);
      fb.delete();
      if (len < 4) begin
         repeat (len) fb.push_back(8'($urandom));
         return;
      end
      fb.push_back(8'($urandom));
      fb.push_back(func);
      repeat (len - 4) fb.push_back(8'($urandom));
      append_crc(corrupt);
   endfunction

   task automatic send_byte(input logic [7:0] b, input logic last);
      int unsigned gap;
      req_type     t;
      gap         = pick_gap();
      t.rx_byte   = b;
      t.last_byte = last;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= t;
      do @(posedge clock); while (!req_ready);
      replies.take_byte(t);
      items_sent++;
   endtask

   task automatic send_frame();
      foreach (fb[i]) begin
         send_byte(fb[i], i == fb.size() - 1);
      end
   endtask

   // sender goes quiet until every reply is back, plus the pipeline tail
   task automatic wait_drain();
      req_valid <= 1'b0;
      while (replies.outstanding() != 0) @(posedge clock);
      repeat (DRAIN_TAIL) @(posedge clock);
   endtask

   // result side: random stalls, one long hold-off on request
   initial begin : rsp_side
      int unsigned n;
      while (reset) @(posedge clock);
      forever begin
         if (hold_rsp) begin
            hold_rsp = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         n = pick_gap();
         if (n > 0) begin
            rsp_ready <= 1'b0;
            repeat (n) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         replies.match_reply(rsp_data);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet <= 0;
      end else if (quiet >= STALL_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end else begin
         quiet <= quiet + 1;
      end
   end

   initial begin : stimulus
      int unsigned frame_no;
      int unsigned len;
      int unsigned r;
      logic [7:0]  func;
      bit          corrupt;

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // short frames are length errors whatever they hold
      fb = '{8'hFF};
      send_frame();
      fb = '{8'h00, FN_READ, 8'h00};
      send_frame();
      // shortest read: value high byte is the crc high byte, low byte reads zero
      fb = '{8'h01, FN_READ};
      append_crc(1'b0);
      send_frame();
      fb = '{8'hFF, FN_READ, 8'h02, 8'hFF, 8'h00};
      append_crc(1'b0);
      send_frame();
      fb = '{8'h11, FN_WRITE, 8'h00};
      append_crc(1'b0);
      send_frame();
      fb = '{8'h01, 8'h83};
      append_crc(1'b1);
      send_frame();
      fb = '{8'h00, 8'h83};
      append_crc(1'b0);
      send_frame();

      frame_no = 0;
      while (items_sent < ITEM_TARGET) begin
         if (frame_no == 10) begin
            // block fills up behind a stalled result side
            hold_rsp = 1'b1;
            calm     = 1'b1;
         end
         if (frame_no == 25) begin
            calm = 1'b0;
         end
         if (frame_no == 130) begin
            calm = 1'b1;
         end
         if (frame_no == 150) begin
            calm = 1'b0;
         end
         if (frame_no % 40 == 39) begin
            wait_drain();
         end

         r = $urandom_range(0, 99);
         if (frame_no == 20) begin
            len = MAX_FRAME;
         end else if (frame_no == 60) begin
            len = MAX_FRAME + 1;
         end else if (frame_no == 100) begin
            len = MAX_FRAME + 40;
         end else if (r < 8) begin
            len = $urandom_range(1, 3);
         end else if (r < 93) begin
            len = $urandom_range(4, 12);
         end else begin
            len = $urandom_range(13, 40);
         end

         r = $urandom_range(0, 99);
         if (r < 40) begin
            func = FN_READ;
         end else if (r < 70) begin
            func = FN_WRITE;
         end else begin
            func = 8'($urandom);
         end
         corrupt = (len <= 40) && ($urandom_range(0, 7) == 0);

         if (len <= 40 && $urandom_range(0, 19) == 0) begin
            // line noise: arbitrary bytes, crc almost never matches
            build_frame((len < 4) ? len : 3, func, 1'b0);
            repeat (len - fb.size()) fb.push_back(8'($urandom));
         end else begin
            build_frame(len, func, corrupt);
         end
         send_frame();
         frame_no++;
      end

      wait_drain();
      if (replies.failures == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

>>> sim.f
hw/rtl/mrc_pkg.sv
hw/rtl/mrc_frame_core.sv
hw/rtl/modbus_rtu_response_checker_top.sv
tb/modbus_rtu_response_checker_top_tb.sv
